// ===== hw/rtl/bvpe_pkg.sv =====
`default_nettype none

package bvpe_pkg;

    // default geometry
    localparam int SCREEN_LINES_DEF   = 224;
    localparam int BYTES_PER_LINE_DEF = 32;

    // field widths
    localparam int OFFSET_W  = 13;
    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 4;
    localparam int COORD_W   = 8;
    localparam int COLOR_W   = 5;
    localparam int MODE_W    = 3;

    // serial divider widths (line length is at most 32 bytes)
    localparam int REM_W     = 5;
    localparam int DIVISOR_W = 6;
    localparam int DIV_CNT_W = $clog2(OFFSET_W + 1);

    // register port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [COORD_W-1:0] coord_t;

    // palette indexes
    localparam color_t C_BLACK      = 5'd0;
    localparam color_t C_RED        = 5'd1;
    localparam color_t C_GREEN      = 5'd2;
    localparam color_t C_YELLOW     = 5'd3;
    localparam color_t C_WHITE      = 5'd4;
    localparam color_t C_CYAN       = 5'd5;
    localparam color_t C_PURPLE     = 5'd6;
    localparam color_t C_BACKGROUND = 5'd16;

    // overlay modes
    localparam logic [MODE_W-1:0] MODE_BASIC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELUXE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REVENGE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESCUE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MONO      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PER_WRITE = 3'd5;

    // register indexes
    localparam logic [2:0] REG_OVERLAY_MODE = 3'd0;
    localparam logic [2:0] REG_SCREEN_FLIP  = 3'd1;
    localparam logic [2:0] REG_SWAP_AXES    = 3'd2;
    localparam logic [2:0] REG_MIRROR_X     = 3'd3;
    localparam logic [2:0] REG_MIRROR_Y     = 3'd4;

    // basic and deluxe band overlay
    function automatic color_t band_basic(input coord_t x, input coord_t y, input logic deluxe);
        color_t c;
        c = C_WHITE;
        if (x >= 8'd16 && x < 8'd72) c = C_GREEN;
        if (x < 8'd16 && y > 8'd16 && y < 8'd134) c = C_GREEN;
        if (deluxe && x >= 8'd72 && x < 8'd192) c = C_YELLOW;
        if (x >= 8'd192 && x < 8'd224) c = C_RED;
        return c;
    endfunction

    // revenge band overlay
    function automatic color_t band_revenge(input coord_t x);
        color_t c;
        c = C_WHITE;
        if (x < 8'd72) c = C_GREEN;
        if (x >= 8'd192 && x < 8'd224) c = C_RED;
        return c;
    endfunction

    // rescue band overlay, bottom line forced black
    function automatic color_t band_rescue(input coord_t x, input coord_t y);
        color_t c;
        c = C_WHITE;
        if (x >= 8'd240 && x < 8'd248)
        begin
            if (y < 8'd72) c = C_CYAN;
            else if (y < 8'd152) c = C_RED;
            else c = C_YELLOW;
        end
        if (x >= 8'd232 && x < 8'd240)
        begin
            if (y < 8'd72) c = C_CYAN;
            else if (y < 8'd160) c = C_GREEN;
            else c = C_YELLOW;
        end
        if (x >= 8'd224 && x < 8'd232)
        begin
            if (y >= 8'd72 && y < 8'd160) c = C_GREEN;
            if (y >= 8'd160) c = C_YELLOW;
        end
        if (x >= 8'd216 && x < 8'd224) c = C_RED;
        if (x >= 8'd192 && x < 8'd216) c = C_PURPLE;
        if (x >= 8'd160 && x < 8'd192) c = C_GREEN;
        if (x >= 8'd128 && x < 8'd160) c = C_CYAN;
        if (x >= 8'd96 && x < 8'd128) c = C_PURPLE;
        if (x >= 8'd64 && x < 8'd96) c = C_YELLOW;
        if (x >= 8'd40 && x < 8'd64) c = C_RED;
        if (x >= 8'd24 && x < 8'd40) c = C_CYAN;
        if (x >= 8'd16 && x < 8'd24) c = C_RED;
        if (x < 8'd16)
        begin
            if (y < 8'd136) c = C_CYAN;
            else if (y < 8'd192) c = C_PURPLE;
            else c = C_CYAN;
        end
        if (y == 8'd223) c = C_BLACK;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bvpe_ram.sv =====
`default_nettype none

module bvpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bvpe_divider.sv =====
`default_nettype none

module bvpe_divider #(
    parameter int DIVISOR = bvpe_pkg::BYTES_PER_LINE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bvpe_pkg::OFFSET_W-1:0] dividend,
    output logic                               done,
    output logic      [bvpe_pkg::COORD_W-1:0]  quotient,
    output logic      [bvpe_pkg::REM_W-1:0]    remainder
);

    localparam logic [bvpe_pkg::DIVISOR_W-1:0] DIV_V = bvpe_pkg::DIVISOR_W'(DIVISOR);
    localparam logic [bvpe_pkg::DIV_CNT_W-1:0] STEPS =
        bvpe_pkg::DIV_CNT_W'(bvpe_pkg::OFFSET_W);
    localparam logic [bvpe_pkg::DIV_CNT_W-1:0] ONE_STEP = bvpe_pkg::DIV_CNT_W'(1);

    logic [bvpe_pkg::OFFSET_W-1:0]  work_reg, work_next;
    logic [bvpe_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [bvpe_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [bvpe_pkg::DIVISOR_W-1:0] trial;
    logic                           fits;

    // one quotient bit per cycle, dividend bits shift out as quotient bits shift in
    always_comb
    begin
        trial     = {rem_reg, work_reg[bvpe_pkg::OFFSET_W-1]};
        fits      = (trial >= DIV_V);
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = STEPS;
        end
        else if (cnt_reg != '0)
        begin
            work_next = {work_reg[bvpe_pkg::OFFSET_W-2:0], fits};
            rem_next  = fits ? bvpe_pkg::REM_W'(trial - DIV_V) : bvpe_pkg::REM_W'(trial);
            cnt_next  = cnt_reg - ONE_STEP;
            done_next = (cnt_reg == ONE_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg[bvpe_pkg::COORD_W-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_vram_pixel_expander_top.sv =====
// A changed byte is read, compared and divided before its first pixel goes out, then
//   one pixel per cycle while out_ready is high; the serial line/column divider takes 13 steps.
// A new byte is taken only in the idle state, once the previous byte is fully handled.
// Reset: config registers clear to 0; video memory is then cleared one byte per cycle,
//   every byte in turn, before the first input transfer.
`default_nettype none

module bitmap_vram_pixel_expander_top #(
    parameter int SCREEN_LINES   = bvpe_pkg::SCREEN_LINES_DEF,
    parameter int BYTES_PER_LINE = bvpe_pkg::BYTES_PER_LINE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bvpe_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [bvpe_pkg::PDATA_W-1:0]  pwdata,
    output logic      [bvpe_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    // byte write channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bvpe_pkg::OFFSET_W-1:0] byte_offset,
    input  wire logic [bvpe_pkg::BYTE_W-1:0]   pixel_byte,
    input  wire logic [bvpe_pkg::CODE_W-1:0]   color_code,
    // pixel channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [bvpe_pkg::COORD_W-1:0]  pixel_x,
    output logic      [bvpe_pkg::COORD_W-1:0]  pixel_y,
    output logic      [bvpe_pkg::COLOR_W-1:0]  color_index,
    output logic                               last_pixel
);

    localparam int MEM_DEPTH = SCREEN_LINES * BYTES_PER_LINE;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [bvpe_pkg::OFFSET_W:0] MEM_DEPTH_V = (bvpe_pkg::OFFSET_W + 1)'(MEM_DEPTH);
    localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(MEM_DEPTH - 1);
    localparam logic [MEM_AW-1:0] ADDR_ONE  = MEM_AW'(1);
    localparam bvpe_pkg::coord_t  LAST_LINE = bvpe_pkg::COORD_W'(SCREEN_LINES - 1);
    localparam bvpe_pkg::coord_t  COORD_ONE = bvpe_pkg::COORD_W'(1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [bvpe_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic flip_reg, flip_next;
    logic swap_reg, swap_next;
    logic mirx_reg, mirx_next;
    logic miry_reg, miry_next;
    logic cfg_write;

    // item registers
    logic [bvpe_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic [bvpe_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic [bvpe_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [MEM_AW-1:0]             clr_reg, clr_next;

    // pixel run registers
    logic [bvpe_pkg::BYTE_W-1:0] bits_reg, bits_next;
    bvpe_pkg::coord_t            x_reg, x_next;
    bvpe_pkg::coord_t            y_reg, y_next;
    bvpe_pkg::color_t            lit_reg, lit_next;
    logic [2:0]                  pix_cnt_reg, pix_cnt_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    bvpe_pkg::coord_t px_reg, px_next;
    bvpe_pkg::coord_t py_reg, py_next;
    bvpe_pkg::color_t col_reg, col_next;
    logic             last_reg, last_next;

    // memory and divider hookup
    logic                        ram_we, ram_re;
    logic [MEM_AW-1:0]           ram_waddr;
    logic [bvpe_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    logic                        div_start, div_done;
    bvpe_pkg::coord_t            div_quot;
    logic [bvpe_pkg::REM_W-1:0]  div_rem;

    bvpe_pkg::coord_t x0;
    bvpe_pkg::color_t lit_sel;
    bvpe_pkg::coord_t tx, ty, sx, sy;
    logic             load_pixel;

    bvpe_ram #(
        .WIDTH (bvpe_pkg::BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (off_reg[MEM_AW-1:0]),
        .rdata (ram_rdata)
    );

    bvpe_divider #(
        .DIVISOR (BYTES_PER_LINE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (off_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // register port write and read
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        flip_next = flip_reg;
        swap_next = swap_reg;
        mirx_next = mirx_reg;
        miry_next = miry_reg;
        if (cfg_write)
        begin
            case (paddr[4:2])
                bvpe_pkg::REG_OVERLAY_MODE: mode_next = pwdata[bvpe_pkg::MODE_W-1:0];
                bvpe_pkg::REG_SCREEN_FLIP:  flip_next = pwdata[0];
                bvpe_pkg::REG_SWAP_AXES:    swap_next = pwdata[0];
                bvpe_pkg::REG_MIRROR_X:     mirx_next = pwdata[0];
                bvpe_pkg::REG_MIRROR_Y:     miry_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            bvpe_pkg::REG_OVERLAY_MODE: prdata = {29'b0, mode_reg};
            bvpe_pkg::REG_SCREEN_FLIP:  prdata = {31'b0, flip_reg};
            bvpe_pkg::REG_SWAP_AXES:    prdata = {31'b0, swap_reg};
            bvpe_pkg::REG_MIRROR_X:     prdata = {31'b0, mirx_reg};
            bvpe_pkg::REG_MIRROR_Y:     prdata = {31'b0, miry_reg};
            default:                    prdata = '0;
        endcase
    end

    // overlay colour of a lit pixel, from the line and the first column of the byte
    assign x0 = {div_rem, 3'b000};

    always_comb
    begin
        case (mode_reg)
            bvpe_pkg::MODE_BASIC:     lit_sel = bvpe_pkg::band_basic(x0, div_quot, 1'b0);
            bvpe_pkg::MODE_DELUXE:    lit_sel = bvpe_pkg::band_basic(x0, div_quot, 1'b1);
            bvpe_pkg::MODE_REVENGE:   lit_sel = bvpe_pkg::band_revenge(x0);
            bvpe_pkg::MODE_RESCUE:    lit_sel = bvpe_pkg::band_rescue(x0, div_quot);
            bvpe_pkg::MODE_PER_WRITE: lit_sel = {1'b0, code_reg};
            default:                  lit_sel = bvpe_pkg::C_WHITE;
        endcase
    end

    // coordinate transform of the current pixel: flip, swap, mirror
    always_comb
    begin
        tx = flip_reg ? ~x_reg : x_reg;
        ty = flip_reg ? (LAST_LINE - y_reg) : y_reg;
        sx = swap_reg ? ty : tx;
        sy = swap_reg ? tx : ty;
        if (mirx_reg) sx = ~sx;
        if (miry_reg) sy = ~sy;
    end

    assign load_pixel = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign in_ready   = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        byte_next      = byte_reg;
        code_next      = code_reg;
        clr_next       = clr_reg;
        bits_next      = bits_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        lit_next       = lit_reg;
        pix_cnt_next   = pix_cnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = off_reg[MEM_AW-1:0];
        ram_wdata      = byte_reg;
        div_start      = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_ONE;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    off_next  = byte_offset;
                    byte_next = pixel_byte;
                    code_next = color_code;
                    if ({1'b0, byte_offset} < MEM_DEPTH_V)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ram_rdata == byte_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_we     = 1'b1;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    bits_next    = byte_reg;
                    x_next       = x0;
                    y_next       = div_quot;
                    lit_next     = lit_sel;
                    pix_cnt_next = '0;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load_pixel)
                begin
                    bits_next    = {1'b0, bits_reg[bvpe_pkg::BYTE_W-1:1]};
                    x_next       = x_reg + COORD_ONE;
                    pix_cnt_next = pix_cnt_reg + 3'd1;
                    if (pix_cnt_reg == 3'd7)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register, one pixel per transfer
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        px_next        = px_reg;
        py_next        = py_reg;
        col_next       = col_reg;
        last_next      = last_reg;
        if (load_pixel)
        begin
            out_valid_next = 1'b1;
            px_next        = sx;
            py_next        = sy;
            last_next      = (pix_cnt_reg == 3'd7);
            if (bits_reg[0])
            begin
                col_next = lit_reg;
            end
            else if (mode_reg == bvpe_pkg::MODE_PER_WRITE)
            begin
                col_next = bvpe_pkg::C_BACKGROUND;
            end
            else
            begin
                col_next = bvpe_pkg::C_BLACK;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pix_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            mode_reg      <= bvpe_pkg::MODE_BASIC;
            flip_reg      <= 1'b0;
            swap_reg      <= 1'b0;
            mirx_reg      <= 1'b0;
            miry_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pix_cnt_reg   <= pix_cnt_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            flip_reg      <= flip_next;
            swap_reg      <= swap_next;
            mirx_reg      <= mirx_next;
            miry_reg      <= miry_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        byte_reg <= byte_next;
        code_reg <= code_next;
        bits_reg <= bits_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        lit_reg  <= lit_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        col_reg  <= col_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign color_index = col_reg;
    assign last_pixel  = last_reg;

`ifndef SYNTHESIS
    // the pixel that closes a run carries the last marker
    a_run_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |=> (out_valid && last_pixel))
        else $error("run closed without last pixel");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // background index appears only in per-write colour mode
    a_background_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg != bvpe_pkg::MODE_PER_WRITE) |->
            (color_index != bvpe_pkg::C_BACKGROUND))
        else $error("background colour outside per-write mode");

    // no memory write from a transfer while the clearing pass runs
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!in_ready && !div_start && !out_valid))
        else $error("activity during memory clear");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;

    import bvpe_pkg::*;

    localparam int VRAM_BYTES    = SCREEN_LINES_DEF * BYTES_PER_LINE_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 50000;
    localparam int LONG_HOLD     = 400;

    // modes with no overlay of their own
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   data;
        logic [CODE_W-1:0]   code;
    } byte_write_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OFFSET_W-1:0] byte_offset = '0;
    logic [BYTE_W-1:0]   pixel_byte = '0;
    logic [CODE_W-1:0]   color_code = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    coord_t              pixel_x;
    coord_t              pixel_y;
    color_t              color_index;
    logic                last_pixel;

    bitmap_vram_pixel_expander_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_offset (byte_offset),
        .pixel_byte  (pixel_byte),
        .color_code  (color_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color_index (color_index),
        .last_pixel  (last_pixel)
    );

    // shadow of video memory and registers
    logic [BYTE_W-1:0] vram_copy [VRAM_BYTES];
    logic [MODE_W-1:0] cfg_mode = MODE_BASIC;
    logic              cfg_flip = 1'b0;
    logic              cfg_swap = 1'b0;
    logic              cfg_mirror_x = 1'b0;
    logic              cfg_mirror_y = 1'b0;

    byte_write_t pending_writes [$];
    byte_write_t recent_writes [$];
    byte_write_t offered_write;
    pixel_t      expected_pixels [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;
    int rx_hold_ack = 0;
    int rx_hold_left = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // basic and deluxe bands
    function automatic color_t basic_band(input coord_t x, input coord_t y, input logic deluxe);
        if (x >= 8'd192 && x < 8'd224) return C_RED;
        if (deluxe && x >= 8'd72 && x < 8'd192) return C_YELLOW;
        if (x >= 8'd16 && x < 8'd72) return C_GREEN;
        if (x < 8'd16 && y > 8'd16 && y < 8'd134) return C_GREEN;
        return C_WHITE;
    endfunction

    function automatic color_t revenge_band(input coord_t x);
        if (x < 8'd72) return C_GREEN;
        if (x >= 8'd192 && x < 8'd224) return C_RED;
        return C_WHITE;
    endfunction

    // rescue bands, bottom line always black
    function automatic color_t rescue_band(input coord_t x, input coord_t y);
        if (y == 8'd223) return C_BLACK;
        if (x < 8'd16) return (y >= 8'd136 && y < 8'd192) ? C_PURPLE : C_CYAN;
        if (x < 8'd24) return C_RED;
        if (x < 8'd40) return C_CYAN;
        if (x < 8'd64) return C_RED;
        if (x < 8'd96) return C_YELLOW;
        if (x < 8'd128) return C_PURPLE;
        if (x < 8'd160) return C_CYAN;
        if (x < 8'd192) return C_GREEN;
        if (x < 8'd216) return C_PURPLE;
        if (x < 8'd224) return C_RED;
        if (x < 8'd232) return (y < 8'd72) ? C_WHITE : (y < 8'd160) ? C_GREEN : C_YELLOW;
        if (x < 8'd240) return (y < 8'd72) ? C_CYAN : (y < 8'd160) ? C_GREEN : C_YELLOW;
        if (x < 8'd248) return (y < 8'd72) ? C_CYAN : (y < 8'd152) ? C_RED : C_YELLOW;
        return C_WHITE;
    endfunction

    // store a byte and queue the eight pixels it produces, if it is in range and changes memory
    task automatic expand_byte_write(input byte_write_t w);
        coord_t line;
        coord_t col_x;
        coord_t px;
        coord_t py;
        coord_t t;
        color_t lit;
        color_t unlit;
        pixel_t pix;
        int     i;
        if (int'(w.offset) >= VRAM_BYTES) return;
        if (vram_copy[w.offset] == w.data) return;
        vram_copy[w.offset] = w.data;
        line  = coord_t'(int'(w.offset) / BYTES_PER_LINE_DEF);
        col_x = coord_t'((int'(w.offset) % BYTES_PER_LINE_DEF) * 8);
        case (cfg_mode)
            MODE_BASIC:     lit = basic_band(col_x, line, 1'b0);
            MODE_DELUXE:    lit = basic_band(col_x, line, 1'b1);
            MODE_REVENGE:   lit = revenge_band(col_x);
            MODE_RESCUE:    lit = rescue_band(col_x, line);
            MODE_PER_WRITE: lit = color_t'(w.code);
            default:        lit = C_WHITE;
        endcase
        unlit = (cfg_mode == MODE_PER_WRITE) ? C_BACKGROUND : C_BLACK;
        for (i = 0; i < 8; i++)
        begin
            px = col_x + coord_t'(i);
            py = line;
            if (cfg_flip)
            begin
                px = 8'd255 - px;
                py = coord_t'(SCREEN_LINES_DEF - 1 - int'(line));
            end
            if (cfg_swap)
            begin
                t  = px;
                px = py;
                py = t;
            end
            if (cfg_mirror_x) px = 8'd255 - px;
            if (cfg_mirror_y) py = 8'd255 - py;
            pix.x     = px;
            pix.y     = py;
            pix.color = w.data[i] ? lit : unlit;
            pix.last  = (i == 7);
            expected_pixels.push_back(pix);
        end
    endtask

    // random write: mostly fresh bytes, some rewrites, some out of range
    function automatic byte_write_t random_write();
        byte_write_t w;
        int          pick;
        pick   = $urandom_range(99);
        w.data = BYTE_W'($urandom_range(255));
        w.code = CODE_W'($urandom_range(15));
        if (pick < 8)
            w.offset = OFFSET_W'($urandom_range(8191, VRAM_BYTES));
        else if (pick < 20 && recent_writes.size() != 0)
        begin
            w = recent_writes[$urandom_range(recent_writes.size() - 1)];
            w.code = CODE_W'($urandom_range(15));
        end
        else if (pick < 35)
            w.offset = OFFSET_W'($urandom_range(BYTES_PER_LINE_DEF - 1)
                + BYTES_PER_LINE_DEF * ($urandom_range(1) ? SCREEN_LINES_DEF - 1
                                       : $urandom_range(SCREEN_LINES_DEF - 1)));
        else
            w.offset = OFFSET_W'($urandom_range(VRAM_BYTES - 1));
        recent_writes.push_back(w);
        if (recent_writes.size() > 8) void'(recent_writes.pop_front());
        return w;
    endfunction

    task automatic push_write(input int off, input int data, input int code);
        byte_write_t w;
        w.offset = OFFSET_W'(off);
        w.data   = BYTE_W'(data);
        w.code   = CODE_W'(code);
        pending_writes.push_back(w);
    endtask

    // register write: setup phase then access phase
    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OVERLAY_MODE: cfg_mode     = val[MODE_W-1:0];
            REG_SCREEN_FLIP:  cfg_flip     = val[0];
            REG_SWAP_AXES:    cfg_swap     = val[0];
            REG_MIRROR_X:     cfg_mirror_x = val[0];
            REG_MIRROR_Y:     cfg_mirror_y = val[0];
            default: ;
        endcase
    endtask

    // wait until every expected pixel is out, then let the block settle
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_writes.size() != 0 || in_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reconfigure(input logic [MODE_W-1:0] mode, input logic flip,
                               input logic swap, input logic mx, input logic my,
                               input int tx_pct, input int rx_pct);
        wait_drained();
        write_reg(REG_OVERLAY_MODE, PDATA_W'(mode));
        write_reg(REG_SCREEN_FLIP, PDATA_W'(flip));
        write_reg(REG_SWAP_AXES, PDATA_W'(swap));
        write_reg(REG_MIRROR_X, PDATA_W'(mx));
        write_reg(REG_MIRROR_Y, PDATA_W'(my));
        @(negedge clk);
        tx_idle_pct  <= tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    // byte write driver
    always @(posedge clk)
    begin : byte_driver
        logic send_next;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expand_byte_write(offered_write);
            if (!in_valid || in_ready)
            begin
                send_next = pending_writes.size() != 0
                    && $urandom_range(99) >= tx_idle_pct;
                if (send_next)
                begin
                    offered_write = pending_writes.pop_front();
                    byte_offset <= offered_write.offset;
                    pixel_byte  <= offered_write.data;
                    color_code  <= offered_write.code;
                end
                in_valid <= send_next;
            end
        end
    end

    // pixel monitor and receiver stalls
    always @(posedge clk)
    begin : pixel_monitor
        pixel_t got;
        pixel_t want;
        if (out_valid && out_ready)
        begin
            got.x     = pixel_x;
            got.y     = pixel_y;
            got.color = color_index;
            got.last  = last_pixel;
            if (expected_pixels.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected pixel transfer: x=%0d y=%0d color=%0d last=%0d",
                             got.x, got.y, got.color, got.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                        $display("pixel mismatch: exp x=%0d y=%0d color=%0d last=%0d, %s",
                                 want.x, want.y, want.color, want.last,
                                 $sformatf("got x=%0d y=%0d color=%0d last=%0d",
                                           got.x, got.y, got.color, got.last));
                    mismatch_count++;
                end
            end
        end
        if (rx_hold_req != rx_hold_ack)
        begin
            rx_hold_left = LONG_HOLD;
            rx_hold_ack  = rx_hold_req;
        end
        else if (rx_hold_left != 0)
            rx_hold_left--;
        out_ready <= rx_hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus sequence
    initial
    begin
        foreach (vram_copy[i]) vram_copy[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // basic bands, corners and band edges, unchanged and ignored bytes
        reconfigure(MODE_BASIC, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        push_write(0, 8'hFF, 4'h0);
        push_write(0, 8'hFF, 4'hF);
        push_write(0, 8'h00, 4'h0);
        push_write(17 * 32, 8'h01, 4'hF);
        push_write(133 * 32 + 1, 8'h80, 4'h0);
        push_write(134 * 32 + 1, 8'hFF, 4'h0);
        push_write(2, 8'hAA, 4'h0);
        push_write(24, 8'h55, 4'h0);
        push_write(28, 8'hFF, 4'h0);
        push_write(VRAM_BYTES - 1, 8'hA5, 4'hF);
        push_write(VRAM_BYTES, 8'hFF, 4'h0);
        push_write(8191, 8'hFF, 4'hF);

        // deluxe bands with screen flip
        reconfigure(MODE_DELUXE, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0);
        push_write(9, 8'hFF, 4'h0);
        push_write(23, 8'hFF, 4'h0);
        push_write(56, 8'h0F, 4'h0);

        // rescue bands with axis swap, bottom line black
        reconfigure(MODE_RESCUE, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0);
        push_write(223 * 32, 8'hFF, 4'h0);
        push_write(100 * 32 + 30, 8'hFF, 4'h0);
        push_write(160 * 32 + 29, 8'hFF, 4'h0);
        push_write(50 * 32 + 28, 8'hFF, 4'h0);
        push_write(150 * 32, 8'hC3, 4'h0);

        // revenge bands with both mirrors
        reconfigure(MODE_REVENGE, 1'b0, 1'b0, 1'b1, 1'b1, 0, 0);
        push_write(8, 8'hFF, 4'h0);
        push_write(5 * 32 + 31, 8'hFF, 4'h0);

        // per-write colour, background for unlit pixels, every transform on
        reconfigure(MODE_PER_WRITE, 1'b1, 1'b1, 1'b1, 1'b1, 0, 0);
        push_write(10, 8'h3C, 4'h0);
        push_write(11, 8'hFF, 4'hF);

        // unused modes fall back to mono
        reconfigure(MODE_SPARE_7, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        push_write(12, 8'h81, 4'h9);
        reconfigure(MODE_SPARE_6, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        push_write(13, 8'h7E, 4'h6);

        // random traffic under varied settings and idling
        reconfigure(MODE_BASIC, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0);
        repeat (20) pending_writes.push_back(random_write());
        reconfigure(MODE_RESCUE, 1'b0, 1'b1, 1'b1, 1'b0, 88, 0);
        repeat (20) pending_writes.push_back(random_write());
        reconfigure(MODE_PER_WRITE, 1'b1, 1'b0, 1'b0, 1'b1, 0, 88);
        repeat (20) pending_writes.push_back(random_write());
        reconfigure(MODE_DELUXE, 1'b1, 1'b1, 1'b1, 1'b1, 13, 13);
        repeat (25) pending_writes.push_back(random_write());

        // long receiver hold-off while the sender keeps offering
        reconfigure(MODE_REVENGE, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
        rx_hold_req <= rx_hold_req + 1;
        repeat (25) pending_writes.push_back(random_write());

        reconfigure(MODE_MONO, 1'b0, 1'b1, 1'b0, 1'b1, 0, 0);
        repeat (14) pending_writes.push_back(random_write());

        wait_drained();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
